FILE: rtl/skf_pkg.sv
package skf_pkg;

  localparam int VAL_W     = 32;
  localparam int DEN_W     = 33;
  localparam int CFG_IDX_W = 1;

  localparam logic [VAL_W-1:0] PROC_NOISE_RESET = 32'd655;
  localparam logic [VAL_W-1:0] MEAS_NOISE_RESET = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_NOISE     = 1'b0,
    CFG_MEASUREMENT_NOISE = 1'b1
  } skf_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_SETUP,
    ST_DIV,
    ST_UPDATE
  } skf_state_t;

  typedef struct packed {
    logic load;
    logic run;
  } skf_ser_ctl_t;

endpackage

FILE: rtl/skf_if.sv
interface skf_meas_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_est_if;
  logic                               valid;
  logic                               ready;
  logic signed [skf_pkg::VAL_W-1:0]   estimate;

  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

interface skf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [skf_pkg::CFG_IDX_W-1:0]    index;
  logic [skf_pkg::VAL_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/skf_cfg_regs.sv
module skf_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  skf_cfg_if.sink                     cfg_ch,
  output logic [skf_pkg::VAL_W-1:0]   proc_noise,
  output logic [skf_pkg::VAL_W-1:0]   meas_noise
);

  logic [skf_pkg::VAL_W-1:0] proc_noise_r, proc_noise_nxt;
  logic [skf_pkg::VAL_W-1:0] meas_noise_r, meas_noise_nxt;
  logic                      wr_beat;

  assign cfg_ch.ready = 1'b1;
  assign wr_beat      = cfg_ch.valid & cfg_ch.ready;

  always_comb begin
    proc_noise_nxt = proc_noise_r;
    meas_noise_nxt = meas_noise_r;
    if (wr_beat) begin
      case (skf_pkg::skf_cfg_idx_t'(cfg_ch.index))
        skf_pkg::CFG_PROCESS_NOISE:     proc_noise_nxt = cfg_ch.data;
        skf_pkg::CFG_MEASUREMENT_NOISE: meas_noise_nxt = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_noise_r <= skf_pkg::PROC_NOISE_RESET;
      meas_noise_r <= skf_pkg::MEAS_NOISE_RESET;
    end else begin
      proc_noise_r <= proc_noise_nxt;
      meas_noise_r <= meas_noise_nxt;
    end
  end

  assign proc_noise = proc_noise_r;
  assign meas_noise = meas_noise_r;

endmodule

FILE: rtl/skf_div.sv
module skf_div (
  input  logic                          clk,
  input  skf_pkg::skf_ser_ctl_t         ctl,
  input  logic [skf_pkg::VAL_W-1:0]     p_mid,
  input  logic [skf_pkg::DEN_W-1:0]     den,
  output logic                          q_bit
);

  localparam int DW = skf_pkg::DEN_W;

  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic          nz_r;
  logic          q_r, q_nxt;
  logic [DW+1:0] sub;
  logic          ge;
  logic [DW-1:0] rem_keep;

  // restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    sub      = {1'b0, rem_r} - {2'b00, den_r};
    ge       = ~sub[DW+1];
    rem_keep = ge ? sub[DW-1:0] : rem_r[DW-1:0];
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (ctl.load) begin
      rem_nxt = {2'b00, p_mid};
    end else if (ctl.run) begin
      rem_nxt = {rem_keep, 1'b0};
      q_nxt   = ge & nz_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (ctl.load) begin
      den_r <= den;
      nz_r  <= (den != '0);
    end
  end

  assign q_bit = q_r;

endmodule

FILE: rtl/skf_mac.sv
module skf_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  skf_pkg::skf_ser_ctl_t               ctl,
  input  logic                                gain_bit,
  input  logic signed [skf_pkg::DEN_W-1:0]    diff,
  input  logic [skf_pkg::VAL_W-1:0]           p_mid,
  output logic signed [skf_pkg::DEN_W-1:0]    delta,
  output logic [skf_pkg::VAL_W-1:0]           cov_new
);

  localparam int DW      = skf_pkg::DEN_W;
  localparam int VW      = skf_pkg::VAL_W;
  localparam int ACC_E_W = FRAC_BITS + DW + 1;
  localparam int ACC_P_W = FRAC_BITS + VW + 1;

  logic signed [ACC_E_W-1:0] acc_e_r, acc_e_nxt;
  logic [ACC_P_W-1:0]        acc_p_r, acc_p_nxt;
  logic signed [ACC_E_W-1:0] diff_ext;
  logic [ACC_P_W-1:0]        pmid_ext;
  logic [ACC_P_W-1:0]        cov_full;

  // gain bits arrive MSB first: acc = 2*acc + bit*operand
  always_comb begin
    diff_ext  = {{(ACC_E_W-DW){diff[DW-1]}}, diff};
    pmid_ext  = {{(ACC_P_W-VW){1'b0}}, p_mid};
    acc_e_nxt = acc_e_r;
    acc_p_nxt = acc_p_r;
    if (ctl.load) begin
      acc_e_nxt = '0;
      acc_p_nxt = '0;
    end else if (ctl.run) begin
      acc_e_nxt = (acc_e_r <<< 1) + (gain_bit ? diff_ext : '0);
      acc_p_nxt = (acc_p_r << 1) + (gain_bit ? pmid_ext : '0);
    end
  end

  always_ff @(posedge clk) begin
    acc_e_r <= acc_e_nxt;
    acc_p_r <= acc_p_nxt;
  end

  // (1 - g) * p = p * 2^F - g * p
  always_comb begin
    cov_full = {1'b0, p_mid, {FRAC_BITS{1'b0}}} - acc_p_r;
    cov_new  = cov_full[FRAC_BITS +: VW];
    delta    = acc_e_r[FRAC_BITS +: DW];
  end

endmodule

FILE: rtl/scalar_kalman_filter_top.sv
// One-dimensional Kalman filter, constant-state model. Each measurement beat
// yields one estimate beat (signed Q16.16 with the default FRAC_BITS). A sample
// passes through the idle state, in which the beat is taken, a prediction and a
// setup state, a division state in which a restoring divider forms one gain bit
// per cycle while two shift-add multipliers consume each bit in the cycle after
// it is formed, and an update state. The update state stretches while the
// previous estimate still waits in the output register. The next sample is
// taken once the update is done; the result sits in an output register until
// the sink takes it.
// Configuration writes (index 0 process noise, 1 measurement noise) are
// accepted at any time and should be made while no sample is in flight.
module scalar_kalman_filter_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  skf_meas_if.sink    in_ch,
  skf_est_if.source   out_ch,
  skf_cfg_if.sink     cfg_ch
);

  localparam int VW       = skf_pkg::VAL_W;
  localparam int DW       = skf_pkg::DEN_W;
  localparam int MQ_W     = SAMPLE_WIDTH + FRAC_BITS;
  localparam int EXT_W    = ((MQ_W > VW) ? MQ_W : VW) + 1;
  localparam int CNT_W    = $clog2(FRAC_BITS + 2);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_DIV  = CNT_W'(FRAC_BITS);
  localparam logic [VW-1:0]    COV_RESET = VW'(64'd1 << FRAC_BITS);
  localparam logic signed [EXT_W-1:0] MQ_MAX = {{(EXT_W-VW){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [EXT_W-1:0] MQ_MIN = {{(EXT_W-VW){1'b1}}, 32'h8000_0000};

  skf_pkg::skf_state_t state_r, state_nxt;

  logic signed [SAMPLE_WIDTH-1:0] meas_r;
  logic signed [VW-1:0]           est_r, est_nxt;
  logic [VW-1:0]                  cov_r;
  logic [VW-1:0]                  pmid_r, pmid_nxt;
  logic signed [DW-1:0]           diff_r, diff_nxt;
  logic [CNT_W-1:0]               cnt_r;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [VW-1:0]           out_est_r;

  logic [VW-1:0]             proc_noise, meas_noise;
  logic [DW-1:0]             pmid_sum;
  logic [DW-1:0]             den;
  logic signed [EXT_W-1:0]   mq_ext;
  logic signed [EXT_W-1:0]   mq_shift;
  logic [VW-1:0]             mq;
  logic                      in_beat;
  logic                      upd_go;
  logic                      q_bit;
  logic signed [DW-1:0]      delta;
  logic [VW-1:0]             cov_new;
  skf_pkg::skf_ser_ctl_t     div_ctl, mac_ctl;

  skf_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .proc_noise (proc_noise),
    .meas_noise (meas_noise)
  );

  skf_div u_div (
    .clk   (clk),
    .ctl   (div_ctl),
    .p_mid (pmid_r),
    .den   (den),
    .q_bit (q_bit)
  );

  skf_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .gain_bit (q_bit),
    .diff     (diff_r),
    .p_mid    (pmid_r),
    .delta    (delta),
    .cov_new  (cov_new)
  );

  // predict: saturated covariance, clamped scaled sample, innovation
  always_comb begin
    pmid_sum = {1'b0, cov_r} + {1'b0, proc_noise};
    pmid_nxt = pmid_sum[VW] ? '1 : pmid_sum[VW-1:0];
    mq_ext   = {{(EXT_W-SAMPLE_WIDTH){meas_r[SAMPLE_WIDTH-1]}}, meas_r};
    mq_shift = mq_ext <<< FRAC_BITS;
    if (mq_shift > MQ_MAX) begin
      mq = 32'h7FFF_FFFF;
    end else if (mq_shift < MQ_MIN) begin
      mq = 32'h8000_0000;
    end else begin
      mq = mq_shift[VW-1:0];
    end
    diff_nxt = $signed({mq[VW-1], mq}) - $signed({est_r[VW-1], est_r});
    den      = {1'b0, pmid_r} + {1'b0, meas_noise};
    est_nxt  = est_r + $signed(delta[VW-1:0]);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skf_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = skf_pkg::ST_PRED;
      skf_pkg::ST_PRED:   state_nxt = skf_pkg::ST_SETUP;
      skf_pkg::ST_SETUP:  state_nxt = skf_pkg::ST_DIV;
      skf_pkg::ST_DIV:    if (cnt_r == CNT_LAST) state_nxt = skf_pkg::ST_UPDATE;
      skf_pkg::ST_UPDATE: if (upd_go) state_nxt = skf_pkg::ST_IDLE;
      default:            state_nxt = skf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = 1'b0;
    div_ctl      = '0;
    mac_ctl      = '0;
    upd_go       = 1'b0;
    case (state_r)
      skf_pkg::ST_IDLE:   in_ch.ready = 1'b1;
      skf_pkg::ST_SETUP: begin
        div_ctl.load = 1'b1;
        mac_ctl.load = 1'b1;
      end
      skf_pkg::ST_DIV: begin
        div_ctl.run = (cnt_r <= CNT_DIV);
        mac_ctl.run = (cnt_r != '0);
      end
      skf_pkg::ST_UPDATE: upd_go = ~out_valid_r | out_ch.ready;
      default: ;
    endcase
  end

  assign in_beat       = in_ch.valid & in_ch.ready;
  assign out_valid_nxt = upd_go ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skf_pkg::ST_IDLE;
      est_r       <= '0;
      cov_r       <= COV_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == skf_pkg::ST_SETUP) begin
        cnt_r <= '0;
      end else if (state_r == skf_pkg::ST_DIV) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (upd_go) begin
        est_r <= est_nxt;
        cov_r <= cov_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) meas_r <= in_ch.measurement;
    if (state_r == skf_pkg::ST_PRED) begin
      pmid_r <= pmid_nxt;
      diff_r <= diff_nxt;
    end
    if (upd_go) out_est_r <= est_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.estimate = out_est_r;

  a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == skf_pkg::ST_UPDATE)
    else $error("result beat raised outside update");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> state_r == skf_pkg::ST_PRED)
    else $error("accepted beat did not start prediction");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skf_pkg::ST_DIV && cnt_r == CNT_LAST) |=> state_r == skf_pkg::ST_UPDATE)
    else $error("gain iteration overran");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> cov_r <= $past(pmid_r))
    else $error("updated covariance above prediction");

endmodule

FILE: tb/tb_scalar_kalman_filter_top.sv
`timescale 1ns / 1ps

module tb_scalar_kalman_filter_top;

  localparam int               SAMPLE_W  = 16;
  localparam int               FRAC      = 16;
  localparam logic [63:0]      ONE_Q16   = 64'd1 << FRAC;
  localparam int               HOLD_LEN  = 300;
  localparam int               HOLD_AT   = 60;
  localparam int               IDLE_LIM  = 4000;
  localparam int               SETTLE    = 30;
  localparam int               RAND_SETS = 8;
  localparam int               SET_ITEMS = 180;
  localparam int               CALM_ITEMS = 100;

  logic clk = 1'b0;
  logic rst_n;

  always #2 clk = ~clk;

  skf_meas_if #(.W(SAMPLE_W)) meas_bus ();
  skf_est_if                  est_bus ();
  skf_cfg_if                  cfg_bus ();

  scalar_kalman_filter_top #(
    .SAMPLE_WIDTH (SAMPLE_W),
    .FRAC_BITS    (FRAC)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (meas_bus),
    .out_ch (est_bus),
    .cfg_ch (cfg_bus)
  );

  // filter state mirror
  logic [31:0]        q_model;
  logic [31:0]        r_model;
  logic [31:0]        cov_model;
  logic signed [31:0] est_model;

  logic signed [SAMPLE_W-1:0] samples_pending[$];
  logic signed [31:0]         est_expected[$];

  int   n_in;
  int   n_out;
  int   n_err;
  int   n_sets;
  logic calm;

  function automatic logic signed [31:0] kalman_predict(logic signed [SAMPLE_W-1:0] meas);
    logic [32:0] p_sum;
    logic [31:0] p_mid;
    logic [63:0] den;
    logic [63:0] gain;
    longint      m_q;
    longint      diff;
    longint      step;
    p_sum = {1'b0, cov_model} + {1'b0, q_model};
    p_mid = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    den   = 64'(p_mid) + 64'(r_model);
    gain  = (den == 64'd0) ? 64'd0 : (64'(p_mid) << FRAC) / den;
    if (gain > ONE_Q16) gain = ONE_Q16;
    m_q = longint'(meas) * longint'(ONE_Q16);
    if (m_q > longint'(32'sh7FFF_FFFF)) m_q = longint'(32'sh7FFF_FFFF);
    if (m_q < -longint'(ONE_Q16 << 15)) m_q = -longint'(ONE_Q16 << 15);
    diff      = m_q - longint'(est_model);
    step      = longint'(gain) * diff;
    est_model = 32'(longint'(est_model) + (step >>> FRAC));
    cov_model = 32'(((ONE_Q16 - gain) * 64'(p_mid)) >> FRAC);
    return est_model;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    n_err++;
    $display("[%0t] MISMATCH %s: expected %h got %h", $realtime, what, exp_v, got_v);
  endtask

  // driver
  int in_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      meas_bus.valid <= 1'b0;
      in_gap         <= 0;
    end else begin
      if (meas_bus.valid && meas_bus.ready) begin
        est_expected.push_back(kalman_predict(meas_bus.measurement));
        n_in++;
      end
      if (!(meas_bus.valid && !meas_bus.ready)) begin
        if (in_gap != 0) begin
          meas_bus.valid <= 1'b0;
          in_gap         <= in_gap - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          meas_bus.valid <= 1'b0;
          in_gap         <= $urandom_range(0, 18);
        end else if (samples_pending.size() != 0) begin
          meas_bus.valid       <= 1'b1;
          meas_bus.measurement <= samples_pending.pop_front();
        end else begin
          meas_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int   out_gap;
  int   hold_left;
  logic held;

  always @(posedge clk) begin
    if (!rst_n) begin
      est_bus.ready <= 1'b0;
      out_gap       <= 0;
      hold_left     <= 0;
      held          <= 1'b0;
    end else begin
      if (est_bus.valid && est_bus.ready) begin
        n_out++;
        if (est_expected.size() == 0)
          report_mismatch("unexpected estimate beat", 32'h0, est_bus.estimate);
        else begin
          logic signed [31:0] exp_est;
          exp_est = est_expected.pop_front();
          if (est_bus.estimate !== exp_est)
            report_mismatch("estimate", exp_est, est_bus.estimate);
        end
      end
      if (hold_left != 0) begin
        est_bus.ready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (!held && n_out >= HOLD_AT) begin
        est_bus.ready <= 1'b0;
        hold_left     <= HOLD_LEN - 1;
        held          <= 1'b1;
      end else if (out_gap != 0) begin
        est_bus.ready <= 1'b0;
        out_gap       <= out_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        est_bus.ready <= 1'b0;
        out_gap       <= $urandom_range(0, 18);
      end else begin
        est_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog
  int idle_cycles;

  always @(posedge clk) begin
    if (!rst_n || (meas_bus.valid && meas_bus.ready) || (est_bus.valid && est_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIM) begin
      $display("[%0t] timeout: %0d samples in, %0d estimates out", $realtime, n_in, n_out);
      $display("tb_scalar_kalman_filter_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic cfg_write(skf_pkg::skf_cfg_idx_t idx, logic [31:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    if (idx == skf_pkg::CFG_PROCESS_NOISE)
      q_model = val;
    else
      r_model = val;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_noise(logic [31:0] q_val, logic [31:0] r_val);
    if ($urandom_range(0, 1)) begin
      cfg_write(skf_pkg::CFG_PROCESS_NOISE, q_val);
      cfg_write(skf_pkg::CFG_MEASUREMENT_NOISE, r_val);
    end else begin
      cfg_write(skf_pkg::CFG_MEASUREMENT_NOISE, r_val);
      cfg_write(skf_pkg::CFG_PROCESS_NOISE, q_val);
    end
    n_sets++;
  endtask

  task automatic drain();
    while (samples_pending.size() != 0 || meas_bus.valid || est_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_noise();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 1000));
      3:       return 32'($urandom_range(0, 1 << 20));
      4:       return 32'($urandom_range(1 << 16, 1 << 24));
      default: return $urandom;
    endcase
  endfunction

  int level;

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      1, 2, 3, 4: begin
        v = level + $urandom_range(0, 64) - 32;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SAMPLE_W'(v);
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    rst_n                = 1'b0;
    calm                 = 1'b0;
    meas_bus.valid       = 1'b0;
    meas_bus.measurement = '0;
    est_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = skf_pkg::CFG_PROCESS_NOISE;
    cfg_bus.data         = '0;
    q_model              = skf_pkg::PROC_NOISE_RESET;
    r_model              = skf_pkg::MEAS_NOISE_RESET;
    cov_model            = 32'(ONE_Q16);
    est_model            = '0;
    n_in                 = 0;
    n_out                = 0;
    n_err                = 0;
    n_sets               = 1;
    level                = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset noise, sample extremes
    samples_pending = '{16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'shFFFF, 16'sh0001,
                        16'sh0000};
    drain();
    // saturated covariance, exact tracking
    set_noise(32'hFFFF_FFFF, 32'h0);
    samples_pending = '{16'sh8000, 16'sh7FFF, 16'sh3039};
    drain();
    set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    samples_pending = '{16'sh7FFF, 16'sh8000};
    drain();
    // covariance collapses to zero, then zero divisor
    set_noise(32'h0, 32'h0);
    samples_pending = '{16'sh0064, 16'sh8000, 16'sh7FFF, 16'sh0005};
    drain();
    set_noise(32'h0, 32'hFFFF_FFFF);
    samples_pending = '{16'sh7FFF, 16'sh8000, 16'sh0001};
    drain();
    set_noise(32'h1, 32'h1);
    samples_pending = '{16'sh8000, 16'sh7FFF};
    drain();

    for (int s = 0; s < RAND_SETS; s++) begin
      set_noise(pick_noise(), pick_noise());
      for (int k = 0; k < SET_ITEMS; k++) begin
        if ($urandom_range(0, 15) == 0) level = $urandom_range(0, 65535) - 32768;
        samples_pending.push_back(pick_sample());
      end
      drain();
    end

    calm <= 1'b1;
    set_noise(skf_pkg::PROC_NOISE_RESET, skf_pkg::MEAS_NOISE_RESET);
    for (int k = 0; k < CALM_ITEMS; k++) samples_pending.push_back(pick_sample());
    drain();

    if (est_expected.size() != 0)
      report_mismatch("estimates never produced", 32'(est_expected.size()), 32'h0);
    $display("Filtered %0d samples under %0d noise settings, %0d estimates checked,",
             n_in, n_sets, n_out);
    $display("including saturated covariance, zero divisor and a long output stall.");
    if (n_err == 0) begin
      $display("tb_scalar_kalman_filter_top passed");
    end else begin
      $display("%0d mismatches", n_err);
      $display("tb_scalar_kalman_filter_top failed");
    end
    $finish;
  end

endmodule
